### sv/assert_macros.svh
// Assertion macros shared by the heap key update block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle.
`define MHKU_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define MHKU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mhku_pkg.sv
// Package for the heap key update block: field widths, default depth,
// controller states and the command/status structs. No dependencies.
package mhku_pkg;

	localparam int KEY_W          = 32;
	localparam int IDX_W          = 6;
	localparam int CNT_W          = 7;
	localparam int DEF_HEAP_DEPTH = 64;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 72;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_EV_OLD,
		ST_RD_UP,
		ST_EV_UP,
		ST_RD_DOWN,
		ST_EV_DOWN,
		ST_PLACE,
		ST_RD_ROOT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_POS,
		RD_PARENT,
		RD_CHILD,
		RD_ROOT
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    take_in;
		rd_sel_t rd_sel;
		logic    keep_old;
		logic    move_up;
		logic    move_down;
		logic    place;
		logic    load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_range;
		logic is_update;
		logic key_greater;
		logic at_root;
		logic up_to_root;
		logic child_wins;
		logic out_free;
	} dp_status_t;

endpackage

### sv/mhku_ram.sv
// Key store: one write port, two registered read ports.
// Depends on mhku_pkg for the key width.
module mhku_ram #(
	parameter int DEPTH = mhku_pkg::DEF_HEAP_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mhku_pkg::KEY_W-1:0]  wdata,
	input  logic                        re0,
	input  logic [AW-1:0]               raddr0,
	output logic [mhku_pkg::KEY_W-1:0]  rdata0,
	input  logic                        re1,
	input  logic [AW-1:0]               raddr1,
	output logic [mhku_pkg::KEY_W-1:0]  rdata1
);
	import mhku_pkg::*;

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re0) begin
			rdata0 <= mem[raddr0];
		end
		if (re1) begin
			rdata1 <= mem[raddr1];
		end
	end

endmodule

### sv/mhku_dp.sv
// Datapath: count register, item registers, sift compares, key store and
// result register. Depends on mhku_pkg and mhku_ram.
module mhku_dp #(
	parameter int HEAP_DEPTH = mhku_pkg::DEF_HEAP_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mhku_pkg::CNT_W-1:0]        cfg_wr_data,
	input  logic                              command,
	input  logic [mhku_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [mhku_pkg::KEY_W-1:0] new_value,
	input  mhku_pkg::dp_cmd_t                 cmd,
	output mhku_pkg::dp_status_t              sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic signed [mhku_pkg::KEY_W-1:0] old_value,
	output logic [mhku_pkg::IDX_W-1:0]        final_index,
	output logic signed [mhku_pkg::KEY_W-1:0] top_value
);
	import mhku_pkg::*;

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int NW = AW + 1;
	localparam int CW = AW + 2;

	logic [CNT_W-1:0]        entries_q;
	logic [NW-1:0]           n_eff;
	logic [NW-1:0]           n_q;
	logic                    upd_q;
	logic signed [KEY_W-1:0] nv_q;
	logic [AW-1:0]           pos_q;
	logic                    status_q;
	logic signed [KEY_W-1:0] old_q;
	logic [IDX_W-1:0]        fin_q;
	logic                    out_valid_q;
	logic                    out_status_q;
	logic signed [KEY_W-1:0] out_old_q;
	logic [IDX_W-1:0]        out_fin_q;
	logic signed [KEY_W-1:0] out_top_q;

	logic [AW-1:0]           parent;
	logic [CW-1:0]           left;
	logic [CW-1:0]           right;
	logic                    l_ok;
	logic                    r_ok;
	logic                    l_win;
	logic                    r_win;
	logic signed [KEY_W-1:0] lead_key;
	logic signed [KEY_W-1:0] best_key;
	logic [CW-1:0]           best_pos;
	logic signed [KEY_W-1:0] rd0;
	logic signed [KEY_W-1:0] rd1;
	logic [KEY_W-1:0]        rd0_raw;
	logic [KEY_W-1:0]        rd1_raw;
	logic                    re0;
	logic                    re1;
	logic [AW-1:0]           ra0;
	logic [AW-1:0]           ra1;
	logic                    we;
	logic signed [KEY_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_wr_en) begin
			entries_q <= cfg_wr_data;
		end
	end

	// count above the store depth saturates
	assign n_eff = (32'(entries_q) > HEAP_DEPTH) ? NW'(HEAP_DEPTH) : NW'(entries_q);

	assign parent = (pos_q - AW'(1)) >> 1;
	assign left   = {1'b0, pos_q, 1'b1};
	assign right  = left + CW'(1);
	assign l_ok   = left < CW'(n_q);
	assign r_ok   = right < CW'(n_q);
	assign rd0    = rd0_raw;
	assign rd1    = rd1_raw;

	// left child wins ties against the right
	always_comb begin
		l_win    = l_ok && (rd0 > nv_q);
		lead_key = l_win ? rd0 : nv_q;
		r_win    = r_ok && (rd1 > lead_key);
		best_key = r_win ? rd1 : rd0;
		best_pos = r_win ? right : left;
	end

	always_comb begin
		re0 = 1'b0;
		re1 = 1'b0;
		ra0 = pos_q;
		ra1 = AW'(right);
		unique case (cmd.rd_sel)
			RD_NONE: begin
			end
			RD_POS: begin
				re0 = 1'b1;
			end
			RD_PARENT: begin
				re0 = 1'b1;
				ra0 = parent;
			end
			RD_CHILD: begin
				re0 = 1'b1;
				re1 = 1'b1;
				ra0 = AW'(left);
			end
			RD_ROOT: begin
				re0 = 1'b1;
				ra0 = '0;
			end
			default: begin
			end
		endcase
	end

	assign we    = cmd.move_up | cmd.move_down | cmd.place;
	assign wdata = cmd.move_up ? rd0 : (cmd.move_down ? best_key : nv_q);

	mhku_ram #(
		.DEPTH (HEAP_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (pos_q),
		.wdata  (wdata),
		.re0    (re0),
		.raddr0 (ra0),
		.rdata0 (rd0_raw),
		.re1    (re1),
		.raddr1 (ra1),
		.rdata1 (rd1_raw)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			upd_q    <= command;
			nv_q     <= new_value;
			pos_q    <= AW'(entry_index);
			n_q      <= n_eff;
			status_q <= !sts.in_range;
			old_q    <= '0;
			fin_q    <= '0;
		end
		if (cmd.keep_old) begin
			old_q <= rd0;
		end
		if (cmd.move_up) begin
			pos_q <= parent;
		end
		if (cmd.move_down) begin
			pos_q <= AW'(best_pos);
		end
		if (cmd.place) begin
			fin_q <= IDX_W'(pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_old_q    <= old_q;
			out_fin_q    <= fin_q;
			out_top_q    <= (n_q != '0) ? rd0 : '0;
		end
	end

	always_comb begin
		sts.in_range    = 32'(entry_index) < 32'(n_eff);
		sts.is_update   = upd_q;
		sts.key_greater = nv_q > rd0;
		sts.at_root     = pos_q == '0;
		sts.up_to_root  = parent == '0;
		sts.child_wins  = l_win | r_win;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign old_value   = out_old_q;
	assign final_index = out_fin_q;
	assign top_value   = out_top_q;

endmodule

### sv/mhku_ctrl.sv
// Controller: sequences the load, sift up and sift down steps.
// Depends on mhku_pkg for states and the command/status structs.
module mhku_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mhku_pkg::dp_status_t sts,
	output mhku_pkg::dp_cmd_t    cmd
);
	import mhku_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.take_in   = 1'b0;
		cmd.rd_sel    = RD_NONE;
		cmd.keep_old  = 1'b0;
		cmd.move_up   = 1'b0;
		cmd.move_down = 1'b0;
		cmd.place     = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d = sts.in_range ? ST_RD_OLD : ST_RD_ROOT;
				end
			end
			ST_RD_OLD: begin
				cmd.rd_sel = RD_POS;
				state_d = ST_EV_OLD;
			end
			ST_EV_OLD: begin
				cmd.keep_old = 1'b1;
				if (!sts.is_update) begin
					state_d = ST_PLACE;
				end else if (sts.key_greater) begin
					state_d = sts.at_root ? ST_PLACE : ST_RD_UP;
				end else begin
					state_d = ST_RD_DOWN;
				end
			end
			ST_RD_UP: begin
				cmd.rd_sel = RD_PARENT;
				state_d = ST_EV_UP;
			end
			ST_EV_UP: begin
				if (sts.key_greater) begin
					cmd.move_up = 1'b1;
					state_d = sts.up_to_root ? ST_PLACE : ST_RD_UP;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_RD_DOWN: begin
				cmd.rd_sel = RD_CHILD;
				state_d = ST_EV_DOWN;
			end
			ST_EV_DOWN: begin
				if (sts.child_wins) begin
					cmd.move_down = 1'b1;
					state_d = ST_RD_DOWN;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d = ST_RD_ROOT;
			end
			ST_RD_ROOT: begin
				cmd.rd_sel = RD_ROOT;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/max_heap_key_update.sv
// Top level of the binary max-heap key update block.
// Depends on mhku_pkg, mhku_ctrl, mhku_dp (with mhku_ram), assert_macros.svh.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  s_       | s_tvalid s_tready s_tdata s_tuser| command, entry_index, new_value
//  m_       | m_tvalid m_tready m_tdata m_tuser| status, old_value, final_index,
//           |                                  | top_value
//  cfg_     | cfg_wr_en cfg_wr_data            | entries_in_use
//
// One word at a time. A load steps through ST_RD_OLD, ST_EV_OLD, ST_PLACE, ST_RD_ROOT,
// ST_DONE; an out-of-range index through ST_RD_ROOT, ST_DONE. An update adds a store
// read, then compare and move, per heap level examined; ST_IDLE precedes the next accept.
// The key store is not cleared on reset; only the count and control reset.
// A held result stalls only the final step; the next word waits in s_.
`include "assert_macros.svh"

module max_heap_key_update #(
	parameter int HEAP_DEPTH = mhku_pkg::DEF_HEAP_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mhku_pkg::S_TDATA_W-1:0]   s_tdata,  // [5:0] entry_index, [37:6] new_value
	input  logic                             s_tuser,  // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mhku_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] old_value, [37:32] final_index,
	                                                   // [69:38] top_value
	output logic                             m_tuser,  // status
	input  logic                             cfg_wr_en,
	input  logic [mhku_pkg::CNT_W-1:0]       cfg_wr_data
);
	import mhku_pkg::*;

	dp_cmd_t                 cmd;
	dp_status_t              sts;
	logic [IDX_W-1:0]        entry_index;
	logic signed [KEY_W-1:0] new_value;
	logic signed [KEY_W-1:0] old_value;
	logic [IDX_W-1:0]        final_index;
	logic signed [KEY_W-1:0] top_value;

	assign entry_index = s_tdata[IDX_W-1:0];
	assign new_value   = s_tdata[IDX_W+KEY_W-1:IDX_W];

	mhku_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhku_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.command     (s_tuser),
		.entry_index (entry_index),
		.new_value   (new_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (m_tuser),
		.old_value   (old_value),
		.final_index (final_index),
		.top_value   (top_value)
	);

	assign m_tdata = {2'b00, top_value, final_index, old_value};

	// an accepted word holds off the next one
	`MHKU_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "busy accept")
	// placing the key is always followed by the root read
	`MHKU_ASSERT_NEXT(a_place_then_root, clk, arst_n, cmd.place, cmd.rd_sel == RD_ROOT, "no root read")
	// one store write source per cycle
	`MHKU_ASSERT(a_one_writer, clk, arst_n, $onehot0({cmd.move_up, cmd.move_down, cmd.place}), "two writes")
	// a result appears only from a result load
	`MHKU_ASSERT(a_valid_source, clk, arst_n, $rose(m_tvalid) |-> $past(cmd.load_out), "stray valid")

endmodule
